// ===== sv/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Types and constants shared by the first-fit frame allocator and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

    localparam int NUM_FRAMES_DEF = 256;

    localparam int ACT_W      = 2;
    localparam int ID_W       = 16;
    localparam int TFR_W      = 9;
    localparam int FSIZE_W    = 17;
    localparam int PSIZE_W    = 25;
    localparam int ADDR_W     = 24;
    localparam int FRAG_W     = 25;
    localparam int RES_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    localparam int DIV_STEPS = PSIZE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [TFR_W-1:0]   TOTAL_FRAMES_RST = TFR_W'(256);
    localparam logic [FSIZE_W-1:0] FRAME_SIZE_RST   = FSIZE_W'(16);
    localparam logic [PSIZE_W-1:0] PROCESS_SIZE_RST = PSIZE_W'(64);

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_SIZE = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ID_W-1:0]  process_id;
    } t_ffa_in;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] start_address;
        logic [FRAG_W-1:0] fragmentation;
        logic [RES_W-1:0]  resident_count;
    } t_ffa_out;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } t_owner;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIT,
        S_FILL,
        S_REL,
        S_FRAG,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== sv/first_fit_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_frame_allocator
// Owner table of frames with first-fit allocation, release by process id,
// external fragmentation and a count of resident processes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in_data  (t_ffa_in)
// output    out        o_out_valid / i_out_stall o_out_data (t_ffa_out)
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// One transaction at a time; the owner table has a single read and write port.
// Allocate: a first-fit search over all NUM_FRAMES entries, a fill of the
// frames needed and a fragmentation scan of the active frames; release: a search
// over all entries plus the scan; query: the scan alone; then an output state
// and a return to idle. Reset clears the table entry by entry, and a
// configuration write recomputes the frame quotient; input stalls meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_frame_allocator import ffa_pkg::*; #(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_ffa_in               i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_ffa_out                   o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW   = $clog2(NUM_FRAMES + 1);
    localparam int XW   = (CW > TFR_W) ? CW : TFR_W;
    localparam int RBW  = CW + FSIZE_W;
    localparam int CMPW = (RBW > PSIZE_W) ? RBW : PSIZE_W;

    t_owner mem [NUM_FRAMES];
    t_owner r_rd;

    t_state r_state, n_state;

    logic [TFR_W-1:0]   r_total_frames;
    logic [FSIZE_W-1:0] r_frame_size;
    logic [PSIZE_W-1:0] r_process_size;
    logic               r_div_go;
    logic [PSIZE_W-1:0] div_q;
    logic               div_busy;

    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_lim, n_lim;
    logic               r_pv, n_pv;
    logic [CW-1:0]      r_pidx, n_pidx;
    logic [RES_W-1:0]   r_resident, n_resident;

    logic [ID_W-1:0]    r_id, n_id;
    logic [PSIZE_W-1:0] r_need, n_need;
    logic [CW-1:0]      r_nact, n_nact;
    logic [CW-1:0]      r_run, n_run;
    logic [CW-1:0]      r_start, n_start;
    logic [ADDR_W-1:0]  r_acc, n_acc;
    logic [ADDR_W-1:0]  r_saddr, n_saddr;
    logic               r_found, n_found;
    logic               r_was, n_was;
    logic [RBW-1:0]     r_rb, n_rb;
    logic [FRAG_W-1:0]  r_sum, n_sum;
    logic               r_status, n_status;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    t_ffa_out           r_out, n_out;

    logic               we;
    logic [AW-1:0]      wa;
    t_owner             wd;
    logic [AW-1:0]      ra;
    logic [XW-1:0]      tf_x;
    logic [CW-1:0]      nact_c;
    logic               scan_done;
    logic               hit;

    function automatic logic [FRAG_W-1:0] frag_add(
        input logic [FRAG_W-1:0]  sum,
        input logic [RBW-1:0]     rb,
        input logic [PSIZE_W-1:0] psize
    );
        logic [FRAG_W:0] tmp;
        begin
            tmp = {1'b0, sum};
            if (CMPW'(rb) < CMPW'(psize)) begin
                tmp = {1'b0, sum} + (FRAG_W + 1)'(rb[PSIZE_W-1:0]);
            end
            return tmp[FRAG_W] ? {FRAG_W{1'b1}} : tmp[FRAG_W-1:0];
        end
    endfunction

    ffa_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_process_size),
        .i_divisor  (r_frame_size),
        .o_quotient (div_q),
        .o_busy     (div_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_frames <= TOTAL_FRAMES_RST;
            r_frame_size   <= FRAME_SIZE_RST;
            r_process_size <= PROCESS_SIZE_RST;
            r_div_go       <= 1'b1;
        end else begin
            r_div_go <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TOTAL_FRAMES: r_total_frames <= i_cfg_data[TFR_W-1:0];
                    CFG_FRAME_SIZE:   r_frame_size   <= i_cfg_data[FSIZE_W-1:0];
                    CFG_PROCESS_SIZE: r_process_size <= i_cfg_data[PSIZE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[ra];
    end

    always_comb begin
        tf_x      = XW'(r_total_frames);
        nact_c    = (tf_x >= XW'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : CW'(tf_x);
        ra        = r_idx[AW-1:0];
        scan_done = (r_idx >= r_lim) && !r_pv;
        hit       = r_rd.valid && (r_rd.id == r_id);

        n_state    = r_state;
        n_idx      = r_idx;
        n_lim      = r_lim;
        n_pv       = 1'b0;
        n_pidx     = r_idx;
        n_resident = r_resident;
        n_id       = r_id;
        n_need     = r_need;
        n_nact     = r_nact;
        n_run      = r_run;
        n_start    = r_start;
        n_acc      = r_acc;
        n_saddr    = r_saddr;
        n_found    = r_found;
        n_was      = r_was;
        n_rb       = r_rb;
        n_sum      = r_sum;
        n_status   = r_status;
        n_addr     = r_addr;
        n_out      = r_out;
        we         = 1'b0;
        wa         = r_idx[AW-1:0];
        wd         = '0;

        if (r_idx < r_lim) begin
            n_pv = 1'b1;
        end

        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == CW'(NUM_FRAMES - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && !r_div_go && !div_busy) begin
                    n_id     = i_in_data.process_id;
                    n_need   = (r_frame_size == '0) ? '0 : div_q;
                    n_nact   = nact_c;
                    n_status = 1'b0;
                    n_addr   = '0;
                    n_idx    = '0;
                    n_run    = '0;
                    n_acc    = '0;
                    n_found  = 1'b0;
                    n_was    = 1'b0;
                    n_rb     = '0;
                    n_sum    = '0;
                    if (i_in_data.action == ACT_ALLOC) begin
                        if ((r_frame_size == '0) || (div_q == '0)) begin
                            n_status = 1'b1;
                            n_lim    = nact_c;
                            n_state  = S_FRAG;
                        end else begin
                            n_lim   = CW'(NUM_FRAMES);
                            n_state = S_FIT;
                        end
                    end else if (i_in_data.action == ACT_RELEASE) begin
                        n_lim   = CW'(NUM_FRAMES);
                        n_state = S_REL;
                    end else begin
                        n_lim   = nact_c;
                        n_state = S_FRAG;
                    end
                end
            end
            S_FIT: begin
                if (r_pv) begin
                    n_acc = r_acc + ADDR_W'(r_frame_size);
                    if (hit) begin
                        n_was = 1'b1;
                    end
                    if (!r_found && (r_pidx < r_nact)) begin
                        if (!r_rd.valid) begin
                            if (r_run == '0) begin
                                n_start = r_pidx;
                                n_saddr = r_acc;
                            end
                            n_run = r_run + 1'b1;
                            if ((PSIZE_W'(r_run) + 1'b1) == r_need) begin
                                n_found = 1'b1;
                            end
                        end else begin
                            n_run = '0;
                        end
                    end
                end
                if (r_pv) begin
                    n_idx  = (r_idx < r_lim) ? r_idx + 1'b1 : r_idx;
                    n_pidx = r_idx;
                end else if (r_idx < r_lim) begin
                    n_idx = r_idx + 1'b1;
                end
                if (scan_done) begin
                    n_pv = 1'b0;
                    if (r_found) begin
                        n_idx   = r_start;
                        n_lim   = r_start + CW'(r_need);
                        n_state = S_FILL;
                    end else begin
                        n_status = 1'b1;
                        n_idx    = '0;
                        n_lim    = r_nact;
                        n_state  = S_FRAG;
                    end
                end
            end
            S_FILL: begin
                n_pv = 1'b0;
                if (r_idx < r_lim) begin
                    we    = 1'b1;
                    wd    = '{valid: 1'b1, id: r_id};
                    n_idx = r_idx + 1'b1;
                end else begin
                    if (!r_was) begin
                        n_resident = r_resident + 1'b1;
                    end
                    n_status = 1'b0;
                    n_addr   = r_saddr;
                    n_idx    = '0;
                    n_lim    = r_nact;
                    n_state  = S_FRAG;
                end
            end
            S_REL: begin
                if (r_pv && hit) begin
                    we    = 1'b1;
                    wa    = r_pidx[AW-1:0];
                    n_was = 1'b1;
                end
                if (r_idx < r_lim) begin
                    n_idx = r_idx + 1'b1;
                end
                if (scan_done) begin
                    n_pv = 1'b0;
                    if (r_was && (r_resident != '0)) begin
                        n_resident = r_resident - 1'b1;
                    end
                    n_idx   = '0;
                    n_lim   = r_nact;
                    n_state = S_FRAG;
                end
            end
            S_FRAG: begin
                if (r_pv) begin
                    if (!r_rd.valid) begin
                        n_rb = r_rb + RBW'(r_frame_size);
                    end else begin
                        n_sum = frag_add(r_sum, r_rb, r_process_size);
                        n_rb  = '0;
                    end
                end
                if (r_idx < r_lim) begin
                    n_idx = r_idx + 1'b1;
                end
                if (scan_done) begin
                    n_pv  = 1'b0;
                    n_out = '{status:         r_status,
                              start_address:  r_addr,
                              fragmentation:  frag_add(r_sum, r_rb, r_process_size),
                              resident_count: r_resident};
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_pv = 1'b0;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_idx      <= '0;
            r_lim      <= '0;
            r_pv       <= 1'b0;
            r_resident <= '0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_lim      <= n_lim;
            r_pv       <= n_pv;
            r_resident <= n_resident;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_id     <= n_id;
        r_need   <= n_need;
        r_nact   <= n_nact;
        r_run    <= n_run;
        r_start  <= n_start;
        r_acc    <= n_acc;
        r_saddr  <= n_saddr;
        r_found  <= n_found;
        r_was    <= n_was;
        r_rb     <= n_rb;
        r_sum    <= n_sum;
        r_status <= n_status;
        r_addr   <= n_addr;
        r_out    <= n_out;
    end

    assign o_in_stall  = !((r_state == S_IDLE) && !r_div_go && !div_busy);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== sv/ffa_divider.sv =====
// ----------------------------------------------------------------------------
// ffa_divider
// Restoring divider, one quotient bit per cycle, for the frames per process.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_divider import ffa_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [PSIZE_W-1:0] i_dividend,
    input  wire logic [FSIZE_W-1:0] i_divisor,
    output logic      [PSIZE_W-1:0] o_quotient,
    output logic                    o_busy
);

    logic                 r_busy, n_busy;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [FSIZE_W:0]     r_rem, n_rem;
    logic [PSIZE_W-1:0]   r_quo, n_quo;
    logic [FSIZE_W-1:0]   r_dvs, n_dvs;
    logic [FSIZE_W:0]     rem_s;
    logic                 ge;

    always_comb begin
        rem_s  = {r_rem[FSIZE_W-1:0], r_quo[PSIZE_W-1]};
        ge     = (rem_s >= {1'b0, r_dvs});
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_STEPS - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? (rem_s - {1'b0, r_dvs}) : rem_s;
            n_quo = {r_quo[PSIZE_W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;

endmodule

`default_nettype wire

// ===== tb/first_fit_frame_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_frame_allocator_tb
// Drives allocate, release and query transactions into the frame allocator
// under several register settings. It keeps its own copy of the owner table,
// predicts each result and compares every field of what the block returns.
// ----------------------------------------------------------------------------

module first_fit_frame_allocator_tb;
    import ffa_pkg::*;

    localparam int NUM_FRAMES = NUM_FRAMES_DEF;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint unsigned FRAG_MAX = (64'd1 << FRAG_W) - 1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_ffa_in               in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_ffa_out              out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_ffa_in  requests [$];
    t_ffa_out predicted [$];
    bit       calm = 1'b0;
    bit       failed = 1'b0;
    int       gap_left = 0;
    int       hold_left = 0;
    t_ffa_out want;

    logic              owner_busy [NUM_FRAMES];
    logic [ID_W-1:0]   owner_pid [NUM_FRAMES];
    logic [RES_W-1:0]  resident_ids;
    logic [TFR_W-1:0]  reg_total_frames;
    logic [FSIZE_W-1:0] reg_frame_size;
    logic [PSIZE_W-1:0] reg_process_size;

    first_fit_frame_allocator #(
        .NUM_FRAMES(NUM_FRAMES)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic t_ffa_out apply_request(t_ffa_in req);
        t_ffa_out res;
        int unsigned span, need, run, first, k;
        bit found, known;
        longint unsigned bytes, total, addr;
        res = '0;
        span = (reg_total_frames < NUM_FRAMES) ? reg_total_frames : NUM_FRAMES;
        if (req.action == ACT_ALLOC) begin
            res.status = 1'b1;
            need = (reg_frame_size != 0) ? reg_process_size / reg_frame_size : 0;
            run = 0;
            first = 0;
            found = 1'b0;
            if (need != 0) begin
                for (k = 0; k < span && !found; k++) begin
                    if (!owner_busy[k]) begin
                        if (run == 0) first = k;
                        run++;
                        found = (run == need);
                    end else begin
                        run = 0;
                    end
                end
            end
            if (found) begin
                known = 1'b0;
                for (k = 0; k < NUM_FRAMES; k++)
                    if (owner_busy[k] && owner_pid[k] == req.process_id) known = 1'b1;
                for (k = first; k < first + need; k++) begin
                    owner_busy[k] = 1'b1;
                    owner_pid[k] = req.process_id;
                end
                if (!known) resident_ids = resident_ids + 1'b1;
                addr = 64'(first) * 64'(reg_frame_size);
                res.status = 1'b0;
                res.start_address = addr[ADDR_W-1:0];
            end
        end else if (req.action == ACT_RELEASE) begin
            known = 1'b0;
            for (k = 0; k < NUM_FRAMES; k++) begin
                if (owner_busy[k] && owner_pid[k] == req.process_id) begin
                    owner_busy[k] = 1'b0;
                    owner_pid[k] = '0;
                    known = 1'b1;
                end
            end
            if (known && resident_ids != 0) resident_ids = resident_ids - 1'b1;
        end
        total = 0;
        run = 0;
        for (k = 0; k <= span; k++) begin
            if (k < span && !owner_busy[k]) begin
                run++;
            end else begin
                bytes = 64'(run) * 64'(reg_frame_size);
                if (bytes < 64'(reg_process_size)) total += bytes;
                run = 0;
            end
        end
        res.fragmentation = (total > FRAG_MAX) ? FRAG_W'(FRAG_MAX) : FRAG_W'(total);
        res.resident_count = resident_ids;
        return res;
    endfunction

    function automatic void check_field(string label, longint unsigned exp_val,
                                        longint unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", label, exp_val, got_val);
            failed = 1'b1;
        end
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !in_stall) predicted = {predicted, apply_request(in_data)};
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (requests.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data <= requests.pop_front();
                    if (!calm && $urandom_range(3) == 0) gap_left = $urandom_range(1, 15);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (!calm && $urandom_range(5) == 0) begin
            hold_left = $urandom_range(14);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (predicted.size() == 0) begin
                $error("result transaction with no expectation pending");
                failed = 1'b1;
            end else begin
                want = predicted.pop_front();
                check_field("status", want.status, out_data.status);
                check_field("start_address", want.start_address, out_data.start_address);
                check_field("fragmentation", want.fragmentation, out_data.fragmentation);
                check_field("resident_count", want.resident_count, out_data.resident_count);
            end
        end
    end

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_TOTAL_FRAMES: reg_total_frames = val[TFR_W-1:0];
            CFG_FRAME_SIZE:   reg_frame_size = val[FSIZE_W-1:0];
            CFG_PROCESS_SIZE: reg_process_size = val[PSIZE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge clk); while (requests.size() > 0 || in_valid || predicted.size() > 0);
    endtask

    task automatic queue_item(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] pid);
        t_ffa_in req;
        req.action = act;
        req.process_id = pid;
        requests = {requests, req};
    endtask

    task automatic queue_mixed_traffic(input int count);
        logic [ID_W-1:0] pool [6];
        int pick;
        foreach (pool[k]) pool[k] = ID_W'($urandom);
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 45)
                queue_item(ACT_ALLOC, pool[$urandom_range(5)]);
            else if (pick < 80)
                queue_item(ACT_RELEASE, pool[$urandom_range(5)]);
            else if (pick < 90)
                queue_item($urandom_range(1) ? ACT_QUERY : ACT_SPARE, pool[$urandom_range(5)]);
            else
                queue_item(ACT_W'($urandom), ID_W'($urandom));
        end
    endtask

    task automatic run_phase(input int unsigned tf, input int unsigned fs,
                             input int unsigned ps, input int count);
        drain();
        set_register(CFG_TOTAL_FRAMES, CFG_DATA_W'(tf));
        set_register(CFG_FRAME_SIZE, CFG_DATA_W'(fs));
        set_register(CFG_PROCESS_SIZE, CFG_DATA_W'(ps));
        queue_mixed_traffic(count);
    endtask

    initial begin
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int unsigned fs;
        foreach (owner_busy[k]) begin
            owner_busy[k] = 1'b0;
            owner_pid[k] = '0;
        end
        resident_ids = '0;
        reg_total_frames = TOTAL_FRAMES_RST;
        reg_frame_size = FRAME_SIZE_RST;
        reg_process_size = PROCESS_SIZE_RST;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset register values: four frames per allocation.
        queue_item(ACT_QUERY, 16'h0000);
        queue_item(ACT_SPARE, 16'hFFFF);
        queue_item(ACT_ALLOC, 16'h0000);
        queue_item(ACT_ALLOC, 16'hFFFF);
        queue_item(ACT_ALLOC, 16'h0000);
        queue_item(ACT_ALLOC, 16'h5A5A);
        queue_item(ACT_RELEASE, 16'h1234);
        queue_item(ACT_RELEASE, 16'h0000);
        queue_item(ACT_ALLOC, 16'hA5A5);
        queue_item(ACT_RELEASE, 16'hFFFF);
        queue_item(ACT_QUERY, 16'h0000);
        queue_mixed_traffic(100);

        drain();
        set_register(CFG_UNUSED, CFG_DATA_W'($urandom));
        run_phase(511, 1, 1, 100);
        run_phase(0, 16, 64, 40);
        run_phase(1, 65536, 65536, 60);
        run_phase(256, 0, 0, 40);
        run_phase(256, 100, 50, 40);
        run_phase(256, 131071, 131071, 110);
        run_phase(256, 131071, 33554431, 60);
        run_phase(256, 65536, 16777216, 50);
        run_phase(37, 3, 20, 120);
        run_phase(200, 1, 8, 110);
        fs = $urandom_range(1, 64);
        run_phase($urandom_range(1, 256), fs,
                  fs * $urandom_range(1, 16) + $urandom_range(fs - 1), 110);
        fs = $urandom_range(1, 64);
        run_phase($urandom_range(1, 256), fs,
                  fs * $urandom_range(1, 16) + $urandom_range(fs - 1), 110);

        drain();
        calm = 1'b1;
        run_phase(256, 16, 64, 110);

        drain();
        repeat (1000) @(posedge clk);
        if (!failed && predicted.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ffa_pkg.sv
sv/ffa_divider.sv
sv/first_fit_frame_allocator.sv
tb/first_fit_frame_allocator_tb.sv
